/* rtl/prim_mst_adjacency_matrix_macros.svh */
// Assertion macros shared by the spanning tree block.
`ifndef PRIM_MST_ADJACENCY_MATRIX_MACROS_SVH
`define PRIM_MST_ADJACENCY_MATRIX_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PRIM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PRIM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/prim_mst_pkg.sv */
// Package: sizes, request and result types of the spanning tree block.
`timescale 1ns / 1ps
package prim_mst_pkg;

	localparam int VERTICES    = 16;
	localparam int WEIGHT_BITS = 16;
	localparam int VIDX_W      = $clog2(VERTICES);
	localparam int ADDR_W      = 2 * VIDX_W;
	localparam int DEPTH       = 1 << ADDR_W;

	typedef struct packed {
		logic [3:0]  row;
		logic [3:0]  column;
		logic [15:0] weight;
		logic        last;
	} prim_mst_req_t;

	typedef struct packed {
		logic [3:0]  from_vertex;
		logic [3:0]  to_vertex;
		logic [15:0] edge_weight;
		logic        found;
		logic        last_edge;
	} prim_mst_res_t;

endpackage

/* rtl/prim_mst_adjacency_matrix.sv */
// Top level: adjacency matrix store and Prim spanning tree sequencer.
`timescale 1ns / 1ps
`include "prim_mst_adjacency_matrix_macros.svh"
// Usage
//  Request channel: a request (row, column, weight, last) is taken at a clock edge with
//  start high and busy low. Each request writes one matrix entry. A request
//  with last set writes its entry and then starts a run from vertex 0.
//  Result channel: strobe is high for one cycle per result; the receiver cannot stall,
//  so every result is delivered in that cycle. A run gives VERTICES-1 results, the final
//  one flagged by last_edge; a round with no candidate edge gives found low, fields zero.
//  Scan: each round sweeps the whole matrix through the single read port of the RAM,
//  one entry a cycle, and gives one result; busy stays high throughout a run and drops
//  in the cycle of the last result.
//  Reset: after arst_n the matrix RAM is cleared to zero, one entry a cycle, with busy
//  high. The matrix is kept between runs.
module prim_mst_adjacency_matrix (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  prim_mst_pkg::prim_mst_req_t request,
	output logic                        busy,
	output logic                        strobe,
	output prim_mst_pkg::prim_mst_res_t result
);
	import prim_mst_pkg::*;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	localparam logic [ADDR_W-1:0] ADDR_LAST  = ADDR_W'(DEPTH - 1);
	localparam logic [VIDX_W-1:0] ROUND_LAST = VIDX_W'(VERTICES - 2);

	state_t               state_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [VERTICES-1:0]  sel_q;
	logic [VIDX_W-1:0]    round_q;
	logic                 have_q;
	logic [WEIGHT_BITS-1:0] best_q;
	logic [VIDX_W-1:0]    bx_q;
	logic [VIDX_W-1:0]    by_q;
	logic                 strobe_q;
	prim_mst_res_t        result_q;

	logic                 rd_vld_s1;
	logic [ADDR_W-1:0]    rd_addr_s1;
	logic [WEIGHT_BITS-1:0] rd_data;

	logic                 ram_we;
	logic [ADDR_W-1:0]    ram_waddr;
	logic [WEIGHT_BITS-1:0] ram_wdata;
	logic                 ram_re;

	logic [VIDX_W-1:0]    rd_row;
	logic [VIDX_W-1:0]    rd_col;
	logic                 hit;
	logic                 fin_have;
	logic [WEIGHT_BITS-1:0] fin_w;
	logic [VIDX_W-1:0]    fin_row;
	logic [VIDX_W-1:0]    fin_col;
	logic                 load_ok;

	// RAM port control: clearing pass, loads, scan reads
	always_comb begin
		load_ok   = (int'(request.row) < VERTICES) && (int'(request.column) < VERTICES);
		ram_we    = (state_q == S_CLEAR) || ((state_q == S_IDLE) && start && load_ok);
		ram_waddr = (state_q == S_CLEAR) ? addr_q
			: {request.row[VIDX_W-1:0], request.column[VIDX_W-1:0]};
		ram_wdata = (state_q == S_CLEAR) ? '0 : request.weight[WEIGHT_BITS-1:0];
		ram_re    = (state_q == S_SCAN);
	end

	prim_mst_ram #(
		.WIDTH(WEIGHT_BITS),
		.DEPTH(DEPTH)
	) u_adj_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(addr_q),
		.rdata(rd_data)
	);

	// candidate test on the entry read last cycle; first lightest wins
	always_comb begin
		rd_row   = rd_addr_s1[ADDR_W-1:VIDX_W];
		rd_col   = rd_addr_s1[VIDX_W-1:0];
		hit      = rd_vld_s1 && sel_q[rd_row] && !sel_q[rd_col] && (rd_data != '0)
			&& (!have_q || (rd_data < best_q));
		fin_have = hit || have_q;
		fin_w    = hit ? rd_data : best_q;
		fin_row  = hit ? rd_row : bx_q;
		fin_col  = hit ? rd_col : by_q;
	end

	// sequencer: state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			addr_q     <= '0;
			sel_q      <= '0;
			round_q    <= '0;
			have_q     <= 1'b0;
			best_q     <= '0;
			bx_q       <= '0;
			by_q       <= '0;
			strobe_q   <= 1'b0;
			result_q   <= '0;
			rd_vld_s1  <= 1'b0;
			rd_addr_s1 <= '0;
		end else begin
			// one result strobe per finished round
			strobe_q   <= (state_q == S_FINISH);
			rd_vld_s1  <= (state_q == S_SCAN);
			rd_addr_s1 <= addr_q;
			unique case (state_q)
				S_CLEAR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == ADDR_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start && request.last) begin
						sel_q   <= VERTICES'(1);
						round_q <= '0;
						have_q  <= 1'b0;
						addr_q  <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					have_q <= fin_have;
					best_q <= fin_w;
					bx_q   <= fin_row;
					by_q   <= fin_col;
					addr_q <= addr_q + 1'b1;
					if (addr_q == ADDR_LAST) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					result_q.found       <= fin_have;
					result_q.from_vertex <= fin_have ? 4'(fin_row) : '0;
					result_q.to_vertex   <= fin_have ? 4'(fin_col) : '0;
					result_q.edge_weight <= fin_have ? 16'(fin_w) : '0;
					result_q.last_edge   <= (round_q == ROUND_LAST);
					if (fin_have) begin
						sel_q[fin_col] <= 1'b1;
					end
					have_q  <= 1'b0;
					round_q <= round_q + 1'b1;
					state_q <= (round_q == ROUND_LAST) ? S_IDLE : S_SCAN;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign strobe = strobe_q;
	assign result = result_q;

	// checks
	`PRIM_ASSERT_SAME(a_last_goes_idle, clk, arst_n,
		strobe && result.last_edge, state_q == S_IDLE,
		"run did not end after last edge")
	`PRIM_ASSERT_SAME(a_found_marks_vertex, clk, arst_n,
		strobe && result.found, sel_q[result.to_vertex[VIDX_W-1:0]],
		"chosen vertex not marked selected")
	`PRIM_ASSERT_NEXT(a_finish_strobes, clk, arst_n,
		state_q == S_FINISH, strobe,
		"round finished without a result")

endmodule

/* rtl/prim_mst_ram.sv */
// Generic single-clock RAM, one write port, one read port, registered read.
`timescale 1ns / 1ps
module prim_mst_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* tb/sv/tb_prim_mst_adjacency_matrix.sv */
// Self-checking testbench for the adjacency matrix Prim spanning tree block.
`timescale 1ns / 1ps
module tb_prim_mst_adjacency_matrix;
	import prim_mst_pkg::*;

	localparam int RANDOM_REQUESTS = 410;
	localparam int ROUND_CYCLES    = VERTICES * VERTICES + 1;
	localparam int RUN_CYCLES      = (VERTICES - 1) * ROUND_CYCLES;
	localparam int CLEAR_CYCLES    = VERTICES * VERTICES;
	localparam int MAX_REPORTS     = 10;

	logic          clk     = 1'b0;
	logic          arst_n  = 1'b0;
	logic          start   = 1'b0;
	prim_mst_req_t request = '0;
	logic          busy;
	logic          strobe;
	prim_mst_res_t result;

	// Local copy of the matrix and the queues between driver, predictor and monitor
	logic [WEIGHT_BITS-1:0] matrix_weights [VERTICES][VERTICES];
	prim_mst_req_t          pending_requests [$];
	prim_mst_res_t          expected_tree_edges [$];

	int          requests_queued = 0;
	int          runs_queued     = 0;
	int          mismatches      = 0;
	int          idle_left       = 0;
	int          accepted_count  = 0;
	bit          holding         = 1'b0;
	bit          idle_free       = 1'b0;
	int unsigned cycle_count     = 0;
	int unsigned cycle_limit     = 32'hFFFF_FFFF;

	prim_mst_adjacency_matrix DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.busy    (busy),
		.strobe  (strobe),
		.result  (result)
	);

	always #5 clk = ~clk;

	// Store one entry; on the final entry grow the tree from vertex 0
	task automatic store_entry_and_run_prim(input prim_mst_req_t req);
		logic [VERTICES-1:0]    in_tree;
		logic [WEIGHT_BITS-1:0] best;
		logic [3:0]             best_from;
		logic [3:0]             best_to;
		bit                     have;
		prim_mst_res_t          edge_res;
		int                     rnd;
		int                     i;
		int                     j;
		if (req.row < VERTICES && req.column < VERTICES)
			matrix_weights[req.row][req.column] = req.weight;
		if (!req.last)
			return;
		in_tree = 1;
		for (rnd = 0; rnd < VERTICES - 1; rnd++) begin
			have      = 1'b0;
			best      = '0;
			best_from = '0;
			best_to   = '0;
			// row-major sweep, strict less-than keeps the first of equal weights
			for (i = 0; i < VERTICES; i++) begin
				if (in_tree[i]) begin
					for (j = 0; j < VERTICES; j++) begin
						if (!in_tree[j] && matrix_weights[i][j] != 0 &&
								(!have || matrix_weights[i][j] < best)) begin
							have      = 1'b1;
							best      = matrix_weights[i][j];
							best_from = i[3:0];
							best_to   = j[3:0];
						end
					end
				end
			end
			if (have)
				in_tree[best_to] = 1'b1;
			edge_res.from_vertex = have ? best_from : 4'd0;
			edge_res.to_vertex   = have ? best_to : 4'd0;
			edge_res.edge_weight = have ? best : 16'd0;
			edge_res.found       = have;
			edge_res.last_edge   = (rnd == VERTICES - 2);
			expected_tree_edges.push_back(edge_res);
		end
	endtask

	task automatic queue_entry(input int r, input int c, input logic [15:0] w, input bit l);
		prim_mst_req_t req;
		req.row    = r[3:0];
		req.column = c[3:0];
		req.weight = w;
		req.last   = l;
		pending_requests.push_back(req);
		requests_queued++;
		if (l)
			runs_queued++;
	endtask

	// Weight mix: absent, small values for ties, extremes, full range
	function automatic logic [15:0] random_weight();
		case ($urandom_range(0, 4))
			0: return 16'd0;
			1: return 16'($urandom_range(1, 6));
			2: return $urandom_range(0, 1) ? 16'hFFFF : 16'd1;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// Spanning tree reachable from vertex 0 in a shuffled order, plus stray entries
	task automatic queue_tree_sequence();
		int               order [VERTICES-1];
		int               k;
		int               t;
		int               tmp;
		int               parent;
		int               extra;
		bit               tie_weights;
		logic [15:0]      w;
		for (k = 0; k < VERTICES - 1; k++)
			order[k] = k + 1;
		for (k = VERTICES - 2; k > 0; k--) begin
			t        = $urandom_range(0, k);
			tmp      = order[k];
			order[k] = order[t];
			order[t] = tmp;
		end
		tie_weights = $urandom_range(0, 1);
		extra       = $urandom_range(0, 4);
		for (k = 0; k < VERTICES - 1; k++) begin
			parent = (k == 0 || $urandom_range(0, 3) == 0) ? 0 : order[$urandom_range(0, k - 1)];
			w = tie_weights ? 16'($urandom_range(1, 6)) : 16'($urandom_range(1, 65535));
			queue_entry(parent, order[k], w, extra == 0 && k == VERTICES - 2);
		end
		for (k = 0; k < extra; k++)
			queue_entry($urandom_range(0, 15), $urandom_range(0, 15), random_weight(),
				k == extra - 1);
	endtask

	// Driver: present the oldest pending request, hold it until taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start     <= 1'b0;
			request   <= '0;
			idle_left = 0;
		end else begin
			if (start && !busy) begin
				store_entry_and_run_prim(request);
				void'(pending_requests.pop_front());
				accepted_count++;
				if (accepted_count % 40 == 0)
					idle_free = ($urandom_range(0, 3) == 0);
				idle_left = idle_free ? 0 : $urandom_range(0, 3);
				holding   = 1'b0;
			end else begin
				holding = start;
			end
			if (!holding) begin
				if (idle_left == 0 && pending_requests.size() != 0) begin
					start   <= 1'b1;
					request <= pending_requests[0];
				end else begin
					start <= 1'b0;
					if (idle_left != 0)
						idle_left--;
				end
			end
		end
	end

	// Monitor: every strobed result against the oldest predicted tree edge
	always @(posedge clk) begin
		if (arst_n && strobe !== 1'b0) begin
			if (expected_tree_edges.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result: %0d-%0d w=%0d found=%b last=%b",
						result.from_vertex, result.to_vertex, result.edge_weight,
						result.found, result.last_edge);
			end else if (result.from_vertex !== expected_tree_edges[0].from_vertex ||
					result.to_vertex !== expected_tree_edges[0].to_vertex ||
					result.edge_weight !== expected_tree_edges[0].edge_weight ||
					result.found !== expected_tree_edges[0].found ||
					result.last_edge !== expected_tree_edges[0].last_edge) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("edge mismatch: expected %0d-%0d w=%0d found=%b last=%b, got %0d-%0d w=%0d found=%b last=%b",
						expected_tree_edges[0].from_vertex, expected_tree_edges[0].to_vertex,
						expected_tree_edges[0].edge_weight, expected_tree_edges[0].found,
						expected_tree_edges[0].last_edge, result.from_vertex,
						result.to_vertex, result.edge_weight, result.found, result.last_edge);
				void'(expected_tree_edges.pop_front());
			end else begin
				void'(expected_tree_edges.pop_front());
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= cycle_limit) begin
			$display("tb_prim_mst_adjacency_matrix: FAIL");
			$finish;
		end
	end

	initial begin
		int kind;
		int n;
		int k;
		int target;
		for (k = 0; k < VERTICES * VERTICES; k++)
			matrix_weights[k / VERTICES][k % VERTICES] = '0;

		// Empty matrix: no round finds a candidate
		queue_entry(0, 0, 16'd0, 1'b1);
		// Self-loop is never a candidate; equal weights go to the first in row-major order
		queue_entry(0, 0, 16'd5, 1'b0);
		queue_entry(0, 3, 16'd7, 1'b0);
		queue_entry(0, 2, 16'd7, 1'b0);
		queue_entry(2, 15, 16'hFFFF, 1'b0);
		queue_entry(3, 15, 16'hFFFF, 1'b0);
		queue_entry(15, 1, 16'd1, 1'b0);
		// back edge into the tree is ignored
		queue_entry(1, 0, 16'd9, 1'b0);
		queue_entry(15, 14, 16'hFFFE, 1'b0);
		// partial tree, remaining rounds find nothing
		queue_entry(14, 8, 16'h8000, 1'b1);
		// rerun on the kept matrix with one edge removed
		queue_entry(2, 15, 16'd0, 1'b1);
		queue_entry(8, 4, 16'd1, 1'b1);

		// Random part: mostly trees, some sparse graphs, some bare loads
		target = requests_queued + RANDOM_REQUESTS;
		while (requests_queued < target) begin
			kind = $urandom_range(0, 9);
			if (kind <= 5) begin
				queue_tree_sequence();
			end else if (kind <= 7) begin
				n = $urandom_range(1, 10);
				for (k = 0; k < n; k++)
					queue_entry($urandom_range(0, 15), $urandom_range(0, 15), random_weight(),
						k == n - 1);
			end else begin
				n = $urandom_range(1, 6);
				for (k = 0; k < n; k++)
					queue_entry($urandom_range(0, 15), $urandom_range(0, 15), random_weight(),
						1'b0);
			end
		end
		cycle_limit = 4 * (runs_queued * (RUN_CYCLES + 1) + requests_queued * 5 +
			CLEAR_CYCLES + RUN_CYCLES + 1000);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() != 0 || expected_tree_edges.size() != 0)
			@(posedge clk);
		repeat (RUN_CYCLES + 100) @(posedge clk);

		if (mismatches == 0)
			$display("tb_prim_mst_adjacency_matrix: PASS");
		else
			$display("tb_prim_mst_adjacency_matrix: FAIL");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/prim_mst_pkg.sv
rtl/prim_mst_ram.sv
rtl/prim_mst_adjacency_matrix.sv
tb/sv/tb_prim_mst_adjacency_matrix.sv
